// ===== hw/rtl/aabb_collide_and_resolve_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the box collision block.
// Each macro expands to one labeled concurrent assertion that is
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef AABB_COLLIDE_AND_RESOLVE_DEFINES_SVH
`define AABB_COLLIDE_AND_RESOLVE_DEFINES_SVH

// Antecedent implies the consequent in the same cycle.
`define ACR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies the consequent in the next cycle.
`define ACR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/acr_pkg.sv =====
// ----------------------------------------------------------------------------
// acr_pkg
// Shared constants, types and helper functions of the box collision block.
// ----------------------------------------------------------------------------
`default_nettype none

package acr_pkg;

	localparam int NUM_BOXES = 16;
	localparam int IDX_W     = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
	localparam int POS_W     = 32;
	localparam int EXT_W     = 31;
	localparam int MASS_W    = 16;
	localparam int EDGE_W    = 36;
	localparam int TOT_W     = MASS_W + 1;
	localparam int MOP_W     = TOT_W + 1;
	localparam int PROD_W    = EDGE_W + MOP_W;
	localparam int MAG_W     = PROD_W - 1;
	localparam int DEN_W     = TOT_W + 1;
	localparam int SUM_W     = MAG_W + 2;
	localparam int DCNT_W    = $clog2(MAG_W + 1);

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_COLLIDE = 2'd1,
		CMD_READ    = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		JOB_POS_HI = 2'd0,
		JOB_POS_LO = 2'd1,
		JOB_VEL_HI = 2'd2,
		JOB_VEL_LO = 2'd3
	} job_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] vel_x;
		logic signed [POS_W-1:0] vel_y;
		logic [EXT_W-1:0]        wide;
		logic [EXT_W-1:0]        tall;
		logic [MASS_W-1:0]       weight;
	} box_t;

	typedef struct packed {
		logic cap_in;
		logic load_wr;
		logic rd_a;
		logic rd_b;
		logic cap_a;
		logic cap_b;
		logic test;
		logic setup;
		logic mul1;
		logic mul2;
		logic div_start;
		logic apply;
		logic wb_a;
		logic wb_b;
		logic emit;
		logic emit_b;
		job_t job;
	} acr_cmd_t;

	typedef struct packed {
		logic is_read;
		logic resolve;
		logic div_done;
		logic out_free;
	} acr_sts_t;

	function automatic logic [IDX_W-1:0] wrap_idx(input logic [3:0] v);
		logic [31:0] t;
		t = 32'(v) % NUM_BOXES;
		return t[IDX_W-1:0];
	endfunction

	function automatic logic [MASS_W-1:0] eff_mass(input logic [MASS_W-1:0] m);
		return (m == '0) ? MASS_W'(1) : m;
	endfunction

	function automatic logic signed [POS_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi_lim;
		logic signed [SUM_W-1:0] lo_lim;
		hi_lim = $signed({{(SUM_W-POS_W){1'b0}}, 1'b0, {(POS_W-1){1'b1}}});
		lo_lim = $signed({{(SUM_W-POS_W){1'b1}}, 1'b1, {(POS_W-1){1'b0}}});
		if (v > hi_lim) begin
			return hi_lim[POS_W-1:0];
		end else if (v < lo_lim) begin
			return lo_lim[POS_W-1:0];
		end else begin
			return v[POS_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/acr_div.sv =====
// ----------------------------------------------------------------------------
// acr_div
// Radix-2 restoring divider for unsigned operands, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_div import acr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [MAG_W-1:0] quo
);

	logic [MAG_W-1:0]  quo_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              done_q;
	logic [DEN_W:0]    shifted;
	logic [DEN_W+1:0]  trial;

	assign shifted = {rem_q, quo_q[MAG_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DCNT_W'(MAG_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - DCNT_W'(1);
				if (cnt_q == DCNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (!trial[DEN_W+1]) begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DEN_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/acr_ctrl.sv =====
// ----------------------------------------------------------------------------
// acr_ctrl
// Command sequencer: steps the datapath through load, read and collide.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_ctrl import acr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] command,
	output logic       in_stall,
	input  acr_sts_t   sts,
	output acr_cmd_t   cmd
);

	typedef enum logic [14:0] {
		S_IDLE   = 15'b000000000000001,
		S_LOAD   = 15'b000000000000010,
		S_RDA    = 15'b000000000000100,
		S_RDB    = 15'b000000000001000,
		S_CAPB   = 15'b000000000010000,
		S_TEST   = 15'b000000000100000,
		S_SETUP  = 15'b000000001000000,
		S_MUL1   = 15'b000000010000000,
		S_MUL2   = 15'b000000100000000,
		S_DSTART = 15'b000001000000000,
		S_DWAIT  = 15'b000010000000000,
		S_APPLY  = 15'b000100000000000,
		S_WBA    = 15'b001000000000000,
		S_WBB    = 15'b010000000000000,
		S_EMIT   = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;
	job_t   job_q, job_d;
	logic   second_q, second_d;

	always_comb begin
		state_d  = state_q;
		job_d    = job_q;
		second_d = second_q;
		cmd      = '0;
		cmd.job  = job_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					second_d   = 1'b0;
					case (command)
						CMD_LOAD:              state_d = S_LOAD;
						CMD_COLLIDE, CMD_READ: state_d = S_RDA;
						default:               state_d = S_IDLE;
					endcase
				end
			end
			S_LOAD: begin
				cmd.load_wr = 1'b1;
				state_d     = S_IDLE;
			end
			S_RDA: begin
				cmd.rd_a = 1'b1;
				state_d  = S_RDB;
			end
			S_RDB: begin
				cmd.cap_a = 1'b1;
				cmd.rd_b  = 1'b1;
				state_d   = sts.is_read ? S_EMIT : S_CAPB;
			end
			S_CAPB: begin
				cmd.cap_b = 1'b1;
				state_d   = S_TEST;
			end
			S_TEST: begin
				cmd.test = 1'b1;
				state_d  = S_SETUP;
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				job_d     = JOB_POS_HI;
				state_d   = sts.resolve ? S_MUL1 : S_EMIT;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_DSTART;
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = S_DWAIT;
			end
			S_DWAIT: begin
				if (sts.div_done) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				if (job_q == JOB_VEL_LO) begin
					state_d = S_WBA;
				end else begin
					job_d   = job_t'(job_q + 2'd1);
					state_d = S_MUL1;
				end
			end
			S_WBA: begin
				cmd.wb_a = 1'b1;
				state_d  = S_WBB;
			end
			S_WBB: begin
				cmd.wb_b = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit   = 1'b1;
					cmd.emit_b = second_q;
					if (sts.is_read || second_q) begin
						state_d = S_IDLE;
					end else begin
						second_d = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			job_q    <= JOB_POS_HI;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			job_q    <= job_d;
			second_q <= second_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/acr_dp.sv =====
// ----------------------------------------------------------------------------
// acr_dp
// Datapath: box table, hit flags, overlap test, resolution arithmetic and
// the output word register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "aabb_collide_and_resolve_defines.svh"

module acr_dp import acr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [1:0]              command,
	input  logic [3:0]              box_a,
	input  logic [3:0]              box_b,
	input  logic signed [POS_W-1:0] load_pos_x,
	input  logic signed [POS_W-1:0] load_pos_y,
	input  logic signed [POS_W-1:0] load_vel_x,
	input  logic signed [POS_W-1:0] load_vel_y,
	input  logic [EXT_W-1:0]        load_width,
	input  logic [EXT_W-1:0]        load_height,
	input  logic [MASS_W-1:0]       load_mass,
	input  acr_cmd_t                cmd,
	output acr_sts_t                sts,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [3:0]              box_index,
	output logic signed [POS_W-1:0] pos_x_out,
	output logic signed [POS_W-1:0] pos_y_out,
	output logic signed [POS_W-1:0] vel_x_out,
	output logic signed [POS_W-1:0] vel_y_out,
	output logic                    overlap_now,
	output logic                    ever_hit,
	output logic                    last_result
);

	box_t                     mem [NUM_BOXES];
	box_t                     rd_q;
	box_t                     in_box_q;
	box_t                     ra_q, rb_q;
	logic [IDX_W-1:0]         idx_a_q, idx_b_q;
	logic                     is_read_q;
	logic [NUM_BOXES-1:0]     hit_flag_q;

	logic signed [EDGE_W-1:0] ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
	logic                     hit_c, xlt_c, ylt_c;
	logic                     hit_q, xlt_q, ylt_q;
	logic signed [EDGE_W-1:0] ox2_q, oy2_q;
	logic                     same;

	logic                     axis_c;
	logic                     axis_x_q, lo_a_q;
	logic signed [EDGE_W-1:0] o2_q;
	logic signed [POS_W-1:0]  pl_q, ph_q, vl_q, vh_q;
	logic [MASS_W-1:0]        ml_q, mh_q;
	logic [TOT_W-1:0]         tot_q;

	logic signed [EDGE_W-1:0] mul_a;
	logic signed [MOP_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [PROD_W-1:0] prod_q, acc_q;
	logic                     is_pos, is_hi;
	logic                     neg_q;

	logic [MAG_W-1:0]         mag, div_num, quo;
	logic [DEN_W-1:0]         div_den;
	logic                     div_busy, div_done;
	logic signed [SUM_W-1:0]  sq, base, sum;
	logic signed [POS_W-1:0]  res;
	logic                     to_a;

	logic                     out_valid_q;
	logic [IDX_W-1:0]         out_idx;
	box_t                     out_box;

	function automatic logic signed [EDGE_W-1:0] edge2(input logic signed [POS_W-1:0] p,
		input logic [EXT_W-1:0] e, input logic upper);
		logic signed [EDGE_W-1:0] p2;
		logic signed [EDGE_W-1:0] ex;
		p2 = $signed({{(EDGE_W-POS_W-1){p[POS_W-1]}}, p, 1'b0});
		ex = $signed({{(EDGE_W-EXT_W){1'b0}}, e});
		return upper ? (p2 + ex) : (p2 - ex);
	endfunction

	// Table access: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			mem[idx_a_q] <= in_box_q;
		end else if (cmd.wb_a) begin
			mem[idx_a_q] <= ra_q;
		end else if (cmd.wb_b) begin
			mem[idx_b_q] <= rb_q;
		end
		if (cmd.rd_a) begin
			rd_q <= mem[idx_a_q];
		end else if (cmd.rd_b) begin
			rd_q <= mem[idx_b_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			idx_a_q          <= wrap_idx(box_a);
			idx_b_q          <= wrap_idx(box_b);
			is_read_q        <= (command == CMD_READ);
			in_box_q.pos_x   <= load_pos_x;
			in_box_q.pos_y   <= load_pos_y;
			in_box_q.vel_x   <= load_vel_x;
			in_box_q.vel_y   <= load_vel_y;
			in_box_q.wide    <= load_width;
			in_box_q.tall    <= load_height;
			in_box_q.weight  <= load_mass;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_flag_q <= '0;
		end else if (cmd.load_wr) begin
			hit_flag_q[idx_a_q] <= 1'b0;
		end else if (cmd.setup && hit_q) begin
			hit_flag_q[idx_a_q] <= 1'b1;
			hit_flag_q[idx_b_q] <= 1'b1;
		end
	end

	// Overlap test on doubled edges.
	always_comb begin
		ax0   = edge2(ra_q.pos_x, ra_q.wide, 1'b0);
		ax1   = edge2(ra_q.pos_x, ra_q.wide, 1'b1);
		ay0   = edge2(ra_q.pos_y, ra_q.tall, 1'b0);
		ay1   = edge2(ra_q.pos_y, ra_q.tall, 1'b1);
		bx0   = edge2(rb_q.pos_x, rb_q.wide, 1'b0);
		bx1   = edge2(rb_q.pos_x, rb_q.wide, 1'b1);
		by0   = edge2(rb_q.pos_y, rb_q.tall, 1'b0);
		by1   = edge2(rb_q.pos_y, rb_q.tall, 1'b1);
		hit_c = !((bx1 <= ax0) || (ax1 <= bx0) || (by1 <= ay0) || (ay1 <= by0));
		xlt_c = (ra_q.pos_x < rb_q.pos_x);
		ylt_c = (ra_q.pos_y < rb_q.pos_y);
	end

	assign same   = (idx_a_q == idx_b_q);
	assign axis_c = (ox2_q < oy2_q);

	always_ff @(posedge clk) begin
		if (cmd.test) begin
			hit_q <= hit_c;
			xlt_q <= xlt_c;
			ylt_q <= ylt_c;
			ox2_q <= xlt_c ? (ax1 - bx0) : (bx1 - ax0);
			oy2_q <= ylt_c ? (ay1 - by0) : (by1 - ay0);
		end
		if (cmd.setup) begin
			axis_x_q <= axis_c;
			o2_q     <= axis_c ? ox2_q : oy2_q;
			if (axis_c ? xlt_q : ylt_q) begin
				lo_a_q <= 1'b1;
				pl_q   <= axis_c ? ra_q.pos_x : ra_q.pos_y;
				ph_q   <= axis_c ? rb_q.pos_x : rb_q.pos_y;
				vl_q   <= axis_c ? ra_q.vel_x : ra_q.vel_y;
				vh_q   <= axis_c ? rb_q.vel_x : rb_q.vel_y;
				ml_q   <= eff_mass(ra_q.weight);
				mh_q   <= eff_mass(rb_q.weight);
			end else begin
				lo_a_q <= 1'b0;
				pl_q   <= axis_c ? rb_q.pos_x : rb_q.pos_y;
				ph_q   <= axis_c ? ra_q.pos_x : ra_q.pos_y;
				vl_q   <= axis_c ? rb_q.vel_x : rb_q.vel_y;
				vh_q   <= axis_c ? ra_q.vel_x : ra_q.vel_y;
				ml_q   <= eff_mass(rb_q.weight);
				mh_q   <= eff_mass(ra_q.weight);
			end
			tot_q <= TOT_W'(eff_mass(ra_q.weight)) + TOT_W'(eff_mass(rb_q.weight));
		end
	end

	// One shared multiplier, operands chosen by step and job.
	assign is_pos = (cmd.job == JOB_POS_HI) || (cmd.job == JOB_POS_LO);
	assign is_hi  = (cmd.job == JOB_POS_HI) || (cmd.job == JOB_VEL_HI);

	always_comb begin
		mul_a = o2_q;
		mul_b = $signed({2'b00, ml_q});
		if (cmd.mul2) begin
			if (cmd.job == JOB_VEL_HI) begin
				mul_a = $signed({{(EDGE_W-POS_W){vl_q[POS_W-1]}}, vl_q});
				mul_b = $signed({2'b00, ml_q});
			end else begin
				mul_a = $signed({{(EDGE_W-POS_W){vh_q[POS_W-1]}}, vh_q});
				mul_b = $signed({2'b00, mh_q});
			end
		end else begin
			case (cmd.job)
				JOB_POS_HI: begin
					mul_a = o2_q;
					mul_b = $signed({2'b00, ml_q});
				end
				JOB_POS_LO: begin
					mul_a = o2_q;
					mul_b = $signed({2'b00, mh_q});
				end
				JOB_VEL_HI: begin
					mul_a = $signed({{(EDGE_W-POS_W){vh_q[POS_W-1]}}, vh_q});
					mul_b = $signed({2'b00, mh_q}) - $signed({2'b00, ml_q});
				end
				default: begin
					mul_a = $signed({{(EDGE_W-POS_W){vl_q[POS_W-1]}}, vl_q});
					mul_b = $signed({2'b00, ml_q}) - $signed({2'b00, mh_q});
				end
			endcase
		end
		mul_p = mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			prod_q <= mul_p;
		end
		if (cmd.mul2) begin
			acc_q <= is_pos ? prod_q : (prod_q + (mul_p <<< 1));
		end
		if (cmd.div_start) begin
			neg_q <= acc_q[PROD_W-1];
		end
	end

	// Round half away from zero: divide the magnitude plus half the divisor.
	always_comb begin
		mag     = acc_q[PROD_W-1] ? MAG_W'(-acc_q) : MAG_W'(acc_q);
		div_num = is_pos ? (mag + MAG_W'(tot_q)) : (mag + MAG_W'(tot_q >> 1));
		div_den = is_pos ? {tot_q, 1'b0} : {1'b0, tot_q};
	end

	acr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (quo)
	);

	always_comb begin
		sq = $signed({2'b00, quo});
		if (neg_q ^ (cmd.job == JOB_POS_LO)) begin
			sq = -sq;
		end
		case (cmd.job)
			JOB_POS_HI: base = SUM_W'(ph_q);
			JOB_POS_LO: base = SUM_W'(pl_q);
			default:    base = '0;
		endcase
		sum  = base + sq;
		res  = sat32(sum);
		to_a = is_hi ? !lo_a_q : lo_a_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			ra_q <= rd_q;
		end else if (cmd.apply && to_a) begin
			if (is_pos) begin
				if (axis_x_q) ra_q.pos_x <= res; else ra_q.pos_y <= res;
			end else begin
				if (axis_x_q) ra_q.vel_x <= res; else ra_q.vel_y <= res;
			end
		end
		if (cmd.cap_b) begin
			rb_q <= rd_q;
		end else if (cmd.apply && !to_a) begin
			if (is_pos) begin
				if (axis_x_q) rb_q.pos_x <= res; else rb_q.pos_y <= res;
			end else begin
				if (axis_x_q) rb_q.vel_x <= res; else rb_q.vel_y <= res;
			end
		end
	end

	// Output word register.
	assign out_idx = cmd.emit_b ? idx_b_q : idx_a_q;
	assign out_box = cmd.emit_b ? rb_q : ra_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			box_index   <= 4'(out_idx);
			pos_x_out   <= out_box.pos_x;
			pos_y_out   <= out_box.pos_y;
			vel_x_out   <= out_box.vel_x;
			vel_y_out   <= out_box.vel_y;
			overlap_now <= is_read_q ? 1'b0 : hit_q;
			ever_hit    <= hit_flag_q[out_idx];
			last_result <= is_read_q || cmd.emit_b;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.is_read  = is_read_q;
	assign sts.resolve  = hit_q && !same;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || !out_stall;

	`ACR_ASSERT_IMP(a_emit_free, clk, arst_n, cmd.emit, !out_valid_q || !out_stall, "emit over a held word")
	`ACR_ASSERT_IMP(a_div_idle, clk, arst_n, cmd.div_start, !div_busy, "divider started while busy")
	`ACR_ASSERT_IMP(a_wb_resolve, clk, arst_n, cmd.wb_a || cmd.wb_b, hit_q && !same, "write-back without resolution")
	`ACR_ASSERT_NXT(a_flag_set, clk, arst_n, cmd.setup && hit_q, hit_flag_q[idx_a_q] && hit_flag_q[idx_b_q], "hit flags not set")

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_collide_and_resolve.sv =====
// ----------------------------------------------------------------------------
// aabb_collide_and_resolve
// Table of 2D boxes with strict overlap test and mass-weighted elastic response.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_stall) takes one command word: load a
// box, read a box, or collide a pair. The output channel (out_valid/out_stall)
// returns box words: none for a load, one for a read, two for a collide (first
// box, then second box, last_result set on the final one).
// The block takes one command at a time; in_stall is high until it finishes.
// A resolving collide runs four rounded divisions on the radix-2 divider,
// each preceded by two multiply steps and followed by an apply step.
// Results sit in an output register; while out_stall is high the word holds
// and the sequencer waits before writing the next word.
// Reset clears all hit flags and the sequencer; box contents are undefined
// until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_collide_and_resolve import acr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              command,
	input  logic [3:0]              box_a,
	input  logic [3:0]              box_b,
	input  logic signed [POS_W-1:0] load_pos_x,
	input  logic signed [POS_W-1:0] load_pos_y,
	input  logic signed [POS_W-1:0] load_vel_x,
	input  logic signed [POS_W-1:0] load_vel_y,
	input  logic [EXT_W-1:0]        load_width,
	input  logic [EXT_W-1:0]        load_height,
	input  logic [MASS_W-1:0]       load_mass,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [3:0]              box_index,
	output logic signed [POS_W-1:0] pos_x_out,
	output logic signed [POS_W-1:0] pos_y_out,
	output logic signed [POS_W-1:0] vel_x_out,
	output logic signed [POS_W-1:0] vel_y_out,
	output logic                    overlap_now,
	output logic                    ever_hit,
	output logic                    last_result
);

	acr_cmd_t cmd;
	acr_sts_t sts;

	acr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	acr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.command     (command),
		.box_a       (box_a),
		.box_b       (box_b),
		.load_pos_x  (load_pos_x),
		.load_pos_y  (load_pos_y),
		.load_vel_x  (load_vel_x),
		.load_vel_y  (load_vel_y),
		.load_width  (load_width),
		.load_height (load_height),
		.load_mass   (load_mass),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.box_index   (box_index),
		.pos_x_out   (pos_x_out),
		.pos_y_out   (pos_y_out),
		.vel_x_out   (vel_x_out),
		.vel_y_out   (vel_y_out),
		.overlap_now (overlap_now),
		.ever_hit    (ever_hit),
		.last_result (last_result)
	);

endmodule

`default_nettype wire

// ===== dv/aabb_collide_and_resolve_tb.sv =====
// ----------------------------------------------------------------------------
// aabb_collide_and_resolve_tb
// Self-checking bench for the box table with overlap test and elastic response.
// A directed table covers extremes, touching edges, the y tie, equal centers,
// a box paired with itself, zero mass and the unused command. It is followed by
// clustered random traffic, so that many collides overlap, with random input gaps
// and output stalls. Every word is checked against an internal predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_collide_and_resolve_tb;
	import acr_pkg::*;

	typedef struct {
		cmd_code_t               cmd;
		logic [3:0]              a;
		logic [3:0]              b;
		logic signed [POS_W-1:0] px, py, vx, vy;
		logic [EXT_W-1:0]        w, h;
		logic [MASS_W-1:0]       m;
	} cmd_word_t;

	typedef struct {
		logic [3:0]              idx;
		logic signed [POS_W-1:0] px, py, vx, vy;
		logic                    ov, hit, last;
	} box_word_t;

	typedef struct {
		cmd_word_t c;
		bit        typed;
		box_word_t r;
	} row_t;

	localparam logic [31:0] ONE = 32'h0001_0000;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [1:0] command;
	logic [3:0] box_a, box_b, box_index;
	logic signed [POS_W-1:0] load_pos_x, load_pos_y, load_vel_x, load_vel_y;
	logic [EXT_W-1:0] load_width, load_height;
	logic [MASS_W-1:0] load_mass;
	logic signed [POS_W-1:0] pos_x_out, pos_y_out, vel_x_out, vel_y_out;
	logic overlap_now, ever_hit, last_result;

	aabb_collide_and_resolve u_top (.*);

	longint tbl_px[16], tbl_py[16], tbl_vx[16], tbl_vy[16], tbl_w[16], tbl_h[16], tbl_m[16];
	bit tbl_hit[16];
	bit loaded[16];
	box_word_t pending[$];
	bit failed;
	bit calm;
	int n_load, n_read, n_coll, n_ovl, n_words;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
		if (v < -64'sh8000_0000) return -64'sh8000_0000;
		return v;
	endfunction

	function automatic longint round_div(longint num, longint den);
		longint mag, q;
		mag = num < 0 ? -num : num;
		q = (mag + den / 2) / den;
		return num < 0 ? -q : q;
	endfunction

	function automatic longint mass_of(int i);
		return tbl_m[i] == 0 ? 1 : tbl_m[i];
	endfunction

	function automatic void push_box(int i, bit ov, bit last);
		box_word_t r;
		r.idx = 4'(i);
		r.px = tbl_px[i][31:0];
		r.py = tbl_py[i][31:0];
		r.vx = tbl_vx[i][31:0];
		r.vy = tbl_vy[i][31:0];
		r.ov = ov;
		r.hit = tbl_hit[i];
		r.last = last;
		pending.push_back(r);
	endfunction

	function automatic void bounce(bit on_y, int lo, int hi, longint o2);
		longint ml, mh, tot, vl, vh, pl, ph, nvh, nvl;
		ml = mass_of(lo);
		mh = mass_of(hi);
		tot = ml + mh;
		vl = on_y ? tbl_vy[lo] : tbl_vx[lo];
		vh = on_y ? tbl_vy[hi] : tbl_vx[hi];
		pl = on_y ? tbl_py[lo] : tbl_px[lo];
		ph = on_y ? tbl_py[hi] : tbl_px[hi];
		ph = clamp32(ph + round_div(o2 * ml, 2 * tot));
		pl = clamp32(pl - round_div(o2 * mh, 2 * tot));
		nvh = clamp32(round_div(vh * (mh - ml) + 2 * vl * ml, tot));
		nvl = clamp32(round_div(vl * (ml - mh) + 2 * vh * mh, tot));
		if (on_y) begin
			tbl_py[hi] = ph; tbl_py[lo] = pl; tbl_vy[hi] = nvh; tbl_vy[lo] = nvl;
		end else begin
			tbl_px[hi] = ph; tbl_px[lo] = pl; tbl_vx[hi] = nvh; tbl_vx[lo] = nvl;
		end
	endfunction

	// Updates the box table for one accepted word and queues the boxes it returns.
	function automatic void predict_boxes(cmd_word_t c);
		int a, b, xl, xr, yl, yh;
		bit hit;
		longint ox2, oy2;
		a = c.a % NUM_BOXES;
		b = c.b % NUM_BOXES;
		case (c.cmd)
			CMD_LOAD: begin
				tbl_px[a] = longint'(c.px); tbl_py[a] = longint'(c.py);
				tbl_vx[a] = longint'(c.vx); tbl_vy[a] = longint'(c.vy);
				tbl_w[a] = longint'(c.w); tbl_h[a] = longint'(c.h);
				tbl_m[a] = longint'(c.m);
				tbl_hit[a] = 1'b0;
				n_load++;
			end
			CMD_READ: begin
				push_box(a, 1'b0, 1'b1);
				n_read++;
			end
			CMD_COLLIDE: begin
				hit = !((2*tbl_px[b] + tbl_w[b]) <= (2*tbl_px[a] - tbl_w[a]) ||
					(2*tbl_px[a] + tbl_w[a]) <= (2*tbl_px[b] - tbl_w[b]) ||
					(2*tbl_py[b] + tbl_h[b]) <= (2*tbl_py[a] - tbl_h[a]) ||
					(2*tbl_py[a] + tbl_h[a]) <= (2*tbl_py[b] - tbl_h[b]));
				if (hit) begin
					tbl_hit[a] = 1'b1;
					tbl_hit[b] = 1'b1;
					n_ovl++;
				end
				if (hit && a != b) begin
					xl = tbl_px[a] < tbl_px[b] ? a : b;
					xr = xl == a ? b : a;
					yl = tbl_py[a] < tbl_py[b] ? a : b;
					yh = yl == a ? b : a;
					ox2 = (2*tbl_px[xl] + tbl_w[xl]) - (2*tbl_px[xr] - tbl_w[xr]);
					oy2 = (2*tbl_py[yl] + tbl_h[yl]) - (2*tbl_py[yh] - tbl_h[yh]);
					if (ox2 < oy2) bounce(1'b0, xl, xr, ox2);
					else bounce(1'b1, yl, yh, oy2);
				end
				push_box(a, hit, 1'b0);
				push_box(b, hit, 1'b1);
				n_coll++;
			end
			default: ;
		endcase
	endfunction

	// Drives one word from a falling edge and returns at the falling edge after acceptance.
	task automatic send_word(cmd_word_t c, bit typed, box_word_t r);
		command <= c.cmd;
		box_a <= c.a;
		box_b <= c.b;
		load_pos_x <= c.px;
		load_pos_y <= c.py;
		load_vel_x <= c.vx;
		load_vel_y <= c.vy;
		load_width <= c.w;
		load_height <= c.h;
		load_mass <= c.m;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_boxes(c);
		if (typed) begin
			void'(pending.pop_back());
			pending.push_back(r);
		end
		if (c.cmd == CMD_LOAD) loaded[c.a % NUM_BOXES] = 1'b1;
		@(negedge clk);
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic idle_gap();
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	function automatic int pick_loaded();
		int i;
		i = $urandom_range(0, 15);
		while (!loaded[i]) i = (i + 1) % 16;
		return i;
	endfunction

	function automatic cmd_word_t random_word();
		cmd_word_t c;
		int r;
		r = $urandom_range(0, 99);
		c.cmd = r < 30 ? CMD_LOAD : r < 80 ? CMD_COLLIDE : r < 96 ? CMD_READ : CMD_NONE;
		c.a = 4'($urandom_range(0, 15));
		c.b = 4'($urandom_range(0, 15));
		if (c.cmd == CMD_LOAD && $urandom_range(0, 9) == 0) begin
			c.px = $urandom; c.py = $urandom; c.vx = $urandom; c.vy = $urandom;
			c.w = 31'($urandom); c.h = 31'($urandom); c.m = 16'($urandom);
		end else begin
			c.px = $signed(32'($urandom_range(0, 32'h10_0000))) - 32'sh8_0000;
			c.py = $signed(32'($urandom_range(0, 32'h10_0000))) - 32'sh8_0000;
			c.vx = $signed(32'($urandom_range(0, 32'h40_0000))) - 32'sh20_0000;
			c.vy = $signed(32'($urandom_range(0, 32'h40_0000))) - 32'sh20_0000;
			c.w = 31'($urandom_range(0, 32'h10_0000));
			c.h = 31'($urandom_range(0, 32'h10_0000));
			c.m = $urandom_range(0, 19) == 0 ? 16'd0 : 16'($urandom_range(1, 16'hFFFF));
		end
		if (c.cmd == CMD_READ || c.cmd == CMD_COLLIDE) c.a = 4'(pick_loaded());
		if (c.cmd == CMD_COLLIDE) c.b = $urandom_range(0, 15) == 0 ? c.a : 4'(pick_loaded());
		return c;
	endfunction

	function automatic row_t mk(cmd_code_t cmd, int a, int b, logic [31:0] px, logic [31:0] py,
			logic [31:0] vx, logic [31:0] vy, logic [30:0] w, logic [30:0] h, logic [15:0] m);
		row_t t;
		t.c = '{cmd, 4'(a), 4'(b), px, py, vx, vy, w, h, m};
		t.typed = 1'b0;
		t.r = '{4'(a), px, py, vx, vy, 1'b0, 1'b0, 1'b1};
		return t;
	endfunction

	// Receiver back-pressure: mostly short stalls, occasionally a long one.
	int stall_left;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 39) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		box_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_words++;
			if (pending.size() == 0) begin
				$error("unexpected box word for index %0d", box_index);
				failed = 1'b1;
			end else begin
				e = pending.pop_front();
				if (box_index !== e.idx) begin
					$error("box_index: expected %0d, got %0d", e.idx, box_index); failed = 1'b1;
				end
				if (pos_x_out !== e.px) begin
					$error("pos_x_out: expected %h, got %h", e.px, pos_x_out); failed = 1'b1;
				end
				if (pos_y_out !== e.py) begin
					$error("pos_y_out: expected %h, got %h", e.py, pos_y_out); failed = 1'b1;
				end
				if (vel_x_out !== e.vx) begin
					$error("vel_x_out: expected %h, got %h", e.vx, vel_x_out); failed = 1'b1;
				end
				if (vel_y_out !== e.vy) begin
					$error("vel_y_out: expected %h, got %h", e.vy, vel_y_out); failed = 1'b1;
				end
				if (overlap_now !== e.ov) begin
					$error("overlap_now: expected %b, got %b", e.ov, overlap_now); failed = 1'b1;
				end
				if (ever_hit !== e.hit) begin
					$error("ever_hit: expected %b, got %b", e.hit, ever_hit); failed = 1'b1;
				end
				if (last_result !== e.last) begin
					$error("last_result: expected %b, got %b", e.last, last_result); failed = 1'b1;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("aabb_collide_and_resolve_tb: FAIL");
		$finish;
	end

	initial begin
		row_t rows[$];
		row_t t;
		cmd_word_t c;
		box_word_t none;
		int k;
		failed = 1'b0;
		calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_NONE;
		box_a = '0; box_b = '0;
		load_pos_x = '0; load_pos_y = '0; load_vel_x = '0; load_vel_y = '0;
		load_width = '0; load_height = '0; load_mass = '0;
		none = '{4'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0};
		for (int i = 0; i < 16; i++) begin
			tbl_px[i] = 0; tbl_py[i] = 0; tbl_vx[i] = 0; tbl_vy[i] = 0;
			tbl_w[i] = 0; tbl_h[i] = 0; tbl_m[i] = 0; tbl_hit[i] = 0; loaded[i] = 0;
		end

		rows.push_back(mk(CMD_LOAD, 0, 0, 0, 0, ONE, 0, 2*ONE, 2*ONE, 16'h0100));
		t = mk(CMD_READ, 0, 0, 0, 0, ONE, 0, 0, 0, 0);
		t.typed = 1'b1;
		rows.push_back(t);
		rows.push_back(mk(CMD_LOAD, 1, 0, ONE, ONE/2, -ONE, 0, 2*ONE, 2*ONE, 16'h0100));
		rows.push_back(mk(CMD_COLLIDE, 0, 1, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(CMD_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(CMD_LOAD, 2, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF));
		t = mk(CMD_READ, 2, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			0, 0, 0);
		t.typed = 1'b1;
		rows.push_back(t);
		rows.push_back(mk(CMD_LOAD, 3, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'h0000));
		rows.push_back(mk(CMD_COLLIDE, 2, 3, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(CMD_COLLIDE, 3, 2, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(CMD_COLLIDE, 2, 2, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(CMD_LOAD, 4, 0, 20*ONE, 20*ONE, ONE, ONE, 2*ONE, 2*ONE, 16'h0001));
		rows.push_back(mk(CMD_LOAD, 5, 0, 22*ONE, 20*ONE, -ONE, 0, 2*ONE, 2*ONE, 16'hFFFF));
		rows.push_back(mk(CMD_COLLIDE, 4, 5, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(CMD_LOAD, 6, 0, 21*ONE, 21*ONE, 0, -ONE, 2*ONE, 2*ONE, 16'h0200));
		rows.push_back(mk(CMD_COLLIDE, 6, 4, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(CMD_LOAD, 7, 0, 21*ONE, 21*ONE, ONE, ONE, 4*ONE, 3*ONE, 16'h0300));
		rows.push_back(mk(CMD_COLLIDE, 6, 7, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(CMD_NONE, 7, 6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF));
		rows.push_back(mk(CMD_LOAD, 15, 0, 0, 0, 0, 0, 0, 0, 16'h0001));
		rows.push_back(mk(CMD_COLLIDE, 15, 0, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk(CMD_READ, 15, 0, 0, 0, 0, 0, 0, 0, 0));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			send_word(rows[i].c, rows[i].typed, rows[i].r);
			idle_gap();
		end

		k = 0;
		while (k < 1600) begin
			calm = (k % 400) >= 340;
			if (k == 800) begin
				in_valid <= 1'b0;
				wait (pending.size() == 0);
				repeat (300) @(negedge clk);
			end
			c = random_word();
			send_word(c, 1'b0, none);
			if (c.cmd != CMD_NONE) k++;
			idle_gap();
		end
		in_valid <= 1'b0;
		calm = 1'b0;
		wait (pending.size() == 0);
		repeat (300) @(posedge clk);

		$display("Covered %0d loads, %0d reads, %0d collides (%0d overlapping), %0d words checked.",
			n_load, n_read, n_coll, n_ovl, n_words);
		if (!failed && pending.size() == 0) begin
			$display("aabb_collide_and_resolve_tb: PASS");
		end else begin
			$display("aabb_collide_and_resolve_tb: FAIL");
		end
		$finish;
	end

endmodule
